// ----- sv/d2bgp_pkg.sv -----
// Shared constants and types for the dosage to BED genotype packer.
package d2bgp_pkg;

	localparam int DOSAGE_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF  = 32;
	localparam int DELTA_W          = 15;
	localparam int DOSAGE_ONE       = 16384;
	localparam int CODE_W           = 2;
	localparam int NUM_CODES        = 4;
	localparam int SLOT_W           = 2;
	localparam int BYTE_W           = 8;

	localparam logic [DELTA_W-1:0] DELTA_RESET = DELTA_W'(819);
	localparam logic [SLOT_W-1:0]  LAST_SLOT   = SLOT_W'(3);

	typedef enum logic [CODE_W-1:0] {
		CODE_HOM_A1  = 2'd0,
		CODE_MISSING = 2'd1,
		CODE_HET     = 2'd2,
		CODE_HOM_A2  = 2'd3
	} code_t;

endpackage

// ----- sv/d2bgp_if.sv -----
// Valid/ready channel interfaces for sample input and packed byte output.
interface d2bgp_in_if import d2bgp_pkg::*; #(
	parameter int DOSAGE_WIDTH = DOSAGE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [DOSAGE_WIDTH-1:0] hap1_dosage;
	logic signed [DOSAGE_WIDTH-1:0] hap2_dosage;
	logic                           last_sample;

	modport source (output valid, hap1_dosage, hap2_dosage, last_sample, input ready);
	modport sink (input valid, hap1_dosage, hap2_dosage, last_sample, output ready);
endinterface

interface d2bgp_out_if import d2bgp_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic [BYTE_W-1:0]      packed_byte;
	logic                   last_byte;
	logic [COUNT_WIDTH-1:0] count_hom_a1;
	logic [COUNT_WIDTH-1:0] count_missing;
	logic [COUNT_WIDTH-1:0] count_het;
	logic [COUNT_WIDTH-1:0] count_hom_a2;

	modport source (output valid, packed_byte, last_byte, count_hom_a1, count_missing,
		count_het, count_hom_a2, input ready);
	modport sink (input valid, packed_byte, last_byte, count_hom_a1, count_missing,
		count_het, count_hom_a2, output ready);
endinterface

// ----- sv/d2bgp_call.sv -----
// Genotype caller: thresholds two haplotype dosages and picks the 2-bit code.
module d2bgp_call import d2bgp_pkg::*; #(
	parameter int DOSAGE_WIDTH = DOSAGE_WIDTH_DEF
) (
	input  logic signed [DOSAGE_WIDTH-1:0] hap1,
	input  logic signed [DOSAGE_WIDTH-1:0] hap2,
	input  logic        [DELTA_W-1:0]      delta,
	output code_t                          code
);

	localparam int CMP_W = ((DOSAGE_WIDTH > DELTA_W + 1) ? DOSAGE_WIDTH : DELTA_W + 1) + 2;

	logic signed [CMP_W-1:0] h1_x;
	logic signed [CMP_W-1:0] h2_x;
	logic signed [CMP_W-1:0] zero_max;
	logic signed [CMP_W-1:0] one_min;
	logic                    h1z, h1o, h2z, h2o;

	assign h1_x     = $signed({{(CMP_W-DOSAGE_WIDTH){hap1[DOSAGE_WIDTH-1]}}, hap1});
	assign h2_x     = $signed({{(CMP_W-DOSAGE_WIDTH){hap2[DOSAGE_WIDTH-1]}}, hap2});
	assign zero_max = $signed({{(CMP_W-DELTA_W){1'b0}}, delta});
	assign one_min  = $signed(CMP_W'(DOSAGE_ONE)) - zero_max;

	assign h1z = h1_x <= zero_max;
	assign h1o = h1_x >= one_min;
	assign h2z = h2_x <= zero_max;
	assign h2o = h2_x >= one_min;

	always_comb begin
		priority if (h1z && h2z) begin
			code = CODE_HOM_A1;
		end else if (h1o && h2o) begin
			code = CODE_HOM_A2;
		end else if ((h1z || h1o) && (h2z || h2o)) begin
			code = CODE_HET;
		end else begin
			code = CODE_MISSING;
		end
	end

endmodule

// ----- sv/d2bgp_pack.sv -----
// Byte packer: slot shift-in, saturating code counters and output register.
module d2bgp_pack import d2bgp_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	input  code_t        item_code,
	input  logic         item_last,
	output logic         item_take,
	d2bgp_out_if.source  byte_out
);

	logic [BYTE_W-1:0]      partial_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [COUNT_WIDTH-1:0] cnt_q    [NUM_CODES];
	logic [COUNT_WIDTH-1:0] cnt_next [NUM_CODES];
	logic                   out_valid_q;
	logic                   emit;
	logic                   out_free;
	logic [BYTE_W-1:0]      byte_next;

	assign emit      = item_last || (slot_q == LAST_SLOT);
	assign out_free  = !out_valid_q || byte_out.ready;
	assign item_take = item_valid && (!emit || out_free);
	assign byte_next = partial_q | (BYTE_W'(item_code) << {slot_q, 1'b0});

	always_comb begin
		for (int k = 0; k < NUM_CODES; k++) begin
			if ((item_code == code_t'(k)) && (cnt_q[k] != '1)) begin
				cnt_next[k] = cnt_q[k] + COUNT_WIDTH'(1);
			end else begin
				cnt_next[k] = cnt_q[k];
			end
		end
	end

	// hold partial byte and counters between transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			slot_q    <= '0;
			for (int k = 0; k < NUM_CODES; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (item_take) begin
			cnt_q <= cnt_next;
			if (emit) begin
				partial_q <= '0;
				slot_q    <= '0;
			end else begin
				partial_q <= byte_next;
				slot_q    <= slot_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_take && emit) begin
			out_valid_q <= 1'b1;
		end else if (byte_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take && emit) begin
			byte_out.packed_byte   <= byte_next;
			byte_out.last_byte     <= item_last;
			byte_out.count_hom_a1  <= cnt_next[CODE_HOM_A1];
			byte_out.count_missing <= cnt_next[CODE_MISSING];
			byte_out.count_het     <= cnt_next[CODE_HET];
			byte_out.count_hom_a2  <= cnt_next[CODE_HOM_A2];
		end
	end

	assign byte_out.valid = out_valid_q;

endmodule

// ----- sv/dosage_to_bed_genotype_packer.sv -----
// Dosage to BED genotype packer top level: input stage, caller, packer.
// Throughput: one sample per cycle unless the byte output stalls; a full or variant-ending
// byte leaves per transfer. The input register takes a sample at its transfer; caller and
// packer then load the result register when it is free, and the byte is valid from there.
// Reset: arst_n clears valids, partial byte, slot and counters, and sets delta to 819.
module dosage_to_bed_genotype_packer import d2bgp_pkg::*; #(
	parameter int DOSAGE_WIDTH = DOSAGE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [DELTA_W-1:0] cfg_wdata,
	d2bgp_in_if.sink           sample_in,
	d2bgp_out_if.source        byte_out
);

	logic [DELTA_W-1:0]             delta_q;
	logic                           valid_s1;
	logic signed [DOSAGE_WIDTH-1:0] hap1_s1;
	logic signed [DOSAGE_WIDTH-1:0] hap2_s1;
	logic                           last_s1;
	code_t                          code;
	logic                           take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q <= DELTA_RESET;
		end else if (cfg_we) begin
			delta_q <= cfg_wdata;
		end
	end

	assign sample_in.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_in.ready) begin
			valid_s1 <= sample_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_in.valid && sample_in.ready) begin
			hap1_s1 <= sample_in.hap1_dosage;
			hap2_s1 <= sample_in.hap2_dosage;
			last_s1 <= sample_in.last_sample;
		end
	end

	d2bgp_call #(
		.DOSAGE_WIDTH (DOSAGE_WIDTH)
	) u_call (
		.hap1  (hap1_s1),
		.hap2  (hap2_s1),
		.delta (delta_q),
		.code  (code)
	);

	d2bgp_pack #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item_code  (code),
		.item_last  (last_s1),
		.item_take  (take),
		.byte_out   (byte_out)
	);

endmodule

// ----- test/tb.sv -----
// Testbench for the dosage to BED genotype packer: directed table, then random variants.
module tb import d2bgp_pkg::*;;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [BYTE_W-1:0]                               packed_byte;
		logic                                            last_byte;
		logic [NUM_CODES-1:0][COUNT_WIDTH_DEF-1:0]       tally;
	} geno_byte_t;

	typedef enum logic {ROW_SAMPLE, ROW_TOLERANCE} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		int          h1;
		int          h2;
		logic        last;
		bit          typed;
		logic [7:0]  want_byte;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [DELTA_W-1:0] cfg_wdata;

	d2bgp_in_if  sample_ch ();
	d2bgp_out_if out_ch ();

	dosage_to_bed_genotype_packer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample_in (sample_ch),
		.byte_out  (out_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [DELTA_W-1:0]                         tolerance = DELTA_RESET;
	logic [BYTE_W-1:0]                          acc_byte  = '0;
	logic [SLOT_W-1:0]                          slot      = '0;
	logic [NUM_CODES-1:0][COUNT_WIDTH_DEF-1:0]  tally_now = '0;

	geno_byte_t geno_bytes [$];
	int         mismatches = 0;
	int         bytes_seen = 0;
	int         cycles     = 0;
	bit         hold_off   = 1'b0;

	row_t plan [25] = '{
		'{ROW_SAMPLE,         0,      0, 1'b1, 1'b1, 8'h00},
		'{ROW_SAMPLE,     16384,  16384, 1'b1, 1'b1, 8'h03},
		'{ROW_SAMPLE,         0,  16384, 1'b1, 1'b1, 8'h02},
		'{ROW_SAMPLE,      8192,      0, 1'b1, 1'b1, 8'h01},
		'{ROW_SAMPLE,    -32768,  32767, 1'b0, 1'b0, 8'h00},
		'{ROW_SAMPLE,     32767, -32768, 1'b0, 1'b0, 8'h00},
		'{ROW_SAMPLE,       819,  15565, 1'b0, 1'b0, 8'h00},
		'{ROW_SAMPLE,       820,  15564, 1'b0, 1'b1, 8'h6A},
		'{ROW_SAMPLE,       819,    819, 1'b0, 1'b0, 8'h00},
		'{ROW_SAMPLE,     15565,  15565, 1'b0, 1'b0, 8'h00},
		'{ROW_SAMPLE,    -32768, -32768, 1'b0, 1'b0, 8'h00},
		'{ROW_SAMPLE,     32767,  32767, 1'b1, 1'b1, 8'hCC},
		'{ROW_SAMPLE,         0,   8192, 1'b0, 1'b0, 8'h00},
		'{ROW_SAMPLE,     16384,      0, 1'b1, 1'b1, 8'h09},
		'{ROW_TOLERANCE,      0,      0, 1'b0, 1'b0, 8'h00},
		'{ROW_SAMPLE,         0,      0, 1'b1, 1'b1, 8'h00},
		'{ROW_SAMPLE,         1,  16384, 1'b1, 1'b1, 8'h01},
		'{ROW_SAMPLE,     16384,      0, 1'b1, 1'b1, 8'h02},
		'{ROW_TOLERANCE,  16384,      0, 1'b0, 1'b0, 8'h00},
		'{ROW_SAMPLE,      8192,   8192, 1'b1, 1'b1, 8'h00},
		'{ROW_SAMPLE,     16385,  16384, 1'b1, 1'b1, 8'h03},
		'{ROW_SAMPLE,        -1,  16385, 1'b1, 1'b1, 8'h02},
		'{ROW_TOLERANCE,  32767,      0, 1'b0, 1'b0, 8'h00},
		'{ROW_SAMPLE,    -32768,  32767, 1'b1, 1'b1, 8'h00},
		'{ROW_TOLERANCE,    819,      0, 1'b0, 1'b0, 8'h00}
	};

	function automatic code_t call_genotype(input logic signed [DOSAGE_WIDTH_DEF-1:0] h1,
		input logic signed [DOSAGE_WIDTH_DEF-1:0] h2);
		int zero_max;
		int one_min;
		bit h1z, h1o, h2z, h2o;
		zero_max = int'(tolerance);
		one_min  = DOSAGE_ONE - zero_max;
		h1z = int'(h1) <= zero_max;
		h1o = int'(h1) >= one_min;
		h2z = int'(h2) <= zero_max;
		h2o = int'(h2) >= one_min;
		if (h1z && h2z)
			return CODE_HOM_A1;
		if (h1o && h2o)
			return CODE_HOM_A2;
		if ((h1z || h1o) && (h2z || h2o))
			return CODE_HET;
		return CODE_MISSING;
	endfunction

	function automatic bit pack_sample(input logic signed [DOSAGE_WIDTH_DEF-1:0] h1,
		input logic signed [DOSAGE_WIDTH_DEF-1:0] h2, input logic last, output geno_byte_t r);
		code_t c;
		c = call_genotype(h1, h2);
		r = '0;
		if (tally_now[c] != '1)
			tally_now[c] = tally_now[c] + 1'b1;
		acc_byte[int'(slot) * 2 +: CODE_W] = c;
		if (slot != LAST_SLOT && !last) begin
			slot = slot + 1'b1;
			return 1'b0;
		end
		r.packed_byte = acc_byte;
		r.last_byte   = last;
		r.tally       = tally_now;
		acc_byte = '0;
		slot     = '0;
		return 1'b1;
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [DOSAGE_WIDTH_DEF-1:0] pick_dosage();
		int d;
		int v;
		d = int'(tolerance);
		case ($urandom_range(0, 9))
			0: v = d;
			1: v = d + 1;
			2: v = DOSAGE_ONE - d;
			3: v = DOSAGE_ONE - d - 1;
			4: v = int'($urandom_range(0, d));
			5: v = DOSAGE_ONE - int'($urandom_range(0, d));
			6: v = int'($urandom_range(0, DOSAGE_ONE));
			7: v = $urandom_range(0, 1) ? 32767 : -32768;
			default: v = int'($urandom_range(0, 65535));
		endcase
		return v[DOSAGE_WIDTH_DEF-1:0];
	endfunction

	function automatic logic [DELTA_W-1:0] pick_tolerance();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return DELTA_W'(16384);
			2: return '1;
			3: return DELTA_RESET;
			4: return DELTA_W'(8192);
			5: return DELTA_W'($urandom_range(0, 16384));
			default: return DELTA_W'($urandom_range(0, 2000));
		endcase
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		$display("t=%0t %s: got %0h, want %0h", $time, what, got, want);
	endtask

	task automatic send_sample(input logic signed [DOSAGE_WIDTH_DEF-1:0] h1,
		input logic signed [DOSAGE_WIDTH_DEF-1:0] h2, input logic last, input int gap,
		input bit typed, input logic [7:0] want_byte);
		geno_byte_t r;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.hap1_dosage <= h1;
		sample_ch.hap2_dosage <= h2;
		sample_ch.last_sample <= last;
		@(posedge clk);
		while (sample_ch.ready !== 1'b1)
			@(posedge clk);
		if (pack_sample(h1, h2, last, r)) begin
			if (typed)
				r.packed_byte = want_byte;
			geno_bytes = {geno_bytes, r};
		end
	endtask

	// hold until every byte is out and the pipe has drained
	task automatic write_tolerance(input logic [DELTA_W-1:0] v);
		sample_ch.valid <= 1'b0;
		while (geno_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tolerance = v;
	endtask

	initial begin : stimulus
		int   ph;
		int   n;
		int   left;
		bit   burst;
		logic last;
		left = 0;
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_wdata             <= '0;
		sample_ch.valid       <= 1'b0;
		sample_ch.hap1_dosage <= '0;
		sample_ch.hap2_dosage <= '0;
		sample_ch.last_sample <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_TOLERANCE)
				write_tolerance(DELTA_W'(plan[i].h1));
			else
				send_sample(16'(plan[i].h1), 16'(plan[i].h2), plan[i].last, idle_gap(),
					plan[i].typed, plan[i].want_byte);
		end

		for (ph = 0; ph < 12; ph++) begin
			write_tolerance(pick_tolerance());
			burst = ($urandom_range(0, 3) == 0);
			for (n = 0; n < 100; n++) begin
				if (left == 0)
					left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
						: $urandom_range(1, 12);
				last = (left == 1);
				left--;
				if ($urandom_range(0, 9) == 0)
					last = $urandom_range(0, 1);
				send_sample(pick_dosage(), pick_dosage(), last, burst ? 0 : idle_gap(),
					1'b0, 8'h00);
			end
		end

		sample_ch.valid <= 1'b0;
		while (geno_bytes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[dosage_to_bed_genotype_packer] OK");
		else
			$display("[dosage_to_bed_genotype_packer] ERROR");
		$finish;
	end

	initial begin : drain
		int gap;
		int calm;
		calm = 0;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off) begin
				hold_off = 1'b0;
				gap = HOLD_CYCLES;
			end else if (calm > 0) begin
				calm--;
				gap = 0;
			end else begin
				gap = idle_gap();
				if ($urandom_range(0, 39) == 0)
					calm = $urandom_range(20, 120);
			end
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin : watch_bytes
		geno_byte_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			bytes_seen++;
			if (bytes_seen == 40 || bytes_seen == 600)
				hold_off = 1'b1;
			if (geno_bytes.size() == 0) begin
				report("byte with nothing pending", {24'h0, out_ch.packed_byte}, 32'h0);
			end else begin
				want = geno_bytes.pop_front();
				if (out_ch.packed_byte !== want.packed_byte)
					report("packed_byte", 32'(out_ch.packed_byte), 32'(want.packed_byte));
				if (out_ch.last_byte !== want.last_byte)
					report("last_byte", 32'(out_ch.last_byte), 32'(want.last_byte));
				if (out_ch.count_hom_a1 !== want.tally[CODE_HOM_A1])
					report("count_hom_a1", out_ch.count_hom_a1, want.tally[CODE_HOM_A1]);
				if (out_ch.count_missing !== want.tally[CODE_MISSING])
					report("count_missing", out_ch.count_missing, want.tally[CODE_MISSING]);
				if (out_ch.count_het !== want.tally[CODE_HET])
					report("count_het", out_ch.count_het, want.tally[CODE_HET]);
				if (out_ch.count_hom_a2 !== want.tally[CODE_HOM_A2])
					report("count_hom_a2", out_ch.count_hom_a2, want.tally[CODE_HOM_A2]);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("[dosage_to_bed_genotype_packer] ERROR");
			$finish;
		end
	end

endmodule

// ----- filelist.f -----
sv/d2bgp_pkg.sv
sv/d2bgp_if.sv
sv/d2bgp_call.sv
sv/d2bgp_pack.sv
sv/dosage_to_bed_genotype_packer.sv
test/tb.sv
